[rtl/core/spgs_pkg.sv]
// Shared types, widths and rounding function for the softened point-mass gravity source.
package spgs_pkg;

	localparam int LANES       = 3;
	localparam int D_W         = 33;
	localparam int MAG_W       = 33;
	localparam int SQ_W        = 66;
	localparam int ESQ_W       = 62;
	localparam int R_W         = 33;
	localparam int X_CHUNK     = 22;
	localparam int PP_W        = X_CHUNK + R_W;
	localparam int DEN_W       = 99;
	localparam int Q_W         = 63;
	localparam int ACC_W       = 64;
	localparam int PROD_W      = 96;
	localparam int SUM_W       = 98;
	localparam int SQRT_STAGES = R_W;
	localparam int DIV_STAGES  = Q_W;
	localparam int PIPE_LAT    = 4 + SQRT_STAGES + 2 + DIV_STAGES + 4;

	localparam logic [30:0] EPS_RESET = 31'd65536;
	localparam logic [32:0] ONE_Q16   = 33'd65536;

	typedef enum logic [2:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_CENTER_Z = 3'd2,
		CFG_EPS      = 3'd3,
		CFG_WIDTH    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] mass_density;
		logic signed [31:0] mom_x;
		logic signed [31:0] mom_y;
		logic signed [31:0] mom_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} point_t;

	typedef struct packed {
		logic signed [31:0] src_mom_x;
		logic signed [31:0] src_mom_y;
		logic signed [31:0] src_mom_z;
		logic signed [31:0] src_energy;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic [SQ_W-1:0]               x;
		logic                          zero;
		logic [LANES-1:0][MAG_W-1:0]   mag;
		logic [LANES-1:0]              neg;
		logic signed [31:0]            rho;
		logic [LANES-1:0][31:0]        mom;
	} sqside_t;

	typedef struct packed {
		logic [LANES-1:0]       neg;
		logic signed [31:0]     rho;
		logic [LANES-1:0][31:0] mom;
	} dlside_t;

	typedef struct packed {
		logic [31:0] value;
		logic        sat;
	} rnd_t;

	// Rounds a Q.46 value to Q16.16, half away from zero, then saturates.
	function automatic rnd_t round_sat(input logic signed [SUM_W-1:0] v);
		logic                neg;
		logic [SUM_W-1:0]    mag;
		logic [SUM_W-1:0]    rnd;
		logic [SUM_W-31:0]   mr;
		rnd_t                r;
		neg = v[SUM_W-1];
		mag = neg ? SUM_W'(-v) : SUM_W'(v);
		rnd = mag + (SUM_W'(1) << 30 >> 1);
		mr  = rnd[SUM_W-1:30];
		r.sat = 1'b0;
		if (neg) begin
			if (mr > (SUM_W-30)'(32'h8000_0000)) begin
				r.sat   = 1'b1;
				r.value = 32'h8000_0000;
			end else begin
				r.value = 32'(-mr);
			end
		end else begin
			if (mr > (SUM_W-30)'(32'h7FFF_FFFF)) begin
				r.sat   = 1'b1;
				r.value = 32'h7FFF_FFFF;
			end else begin
				r.value = mr[31:0];
			end
		end
		return r;
	endfunction

endpackage

[rtl/core/spgs_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with a travelling side beat.
module spgs_isqrt
	import spgs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [SQ_W-1:0] s,
	input  sqside_t         in_side,
	output logic            out_vld,
	output logic [R_W-1:0]  root,
	output sqside_t         out_side
);

	logic            vld_s  [SQRT_STAGES+1];
	logic [SQ_W-1:0] rem_s  [SQRT_STAGES+1];
	logic [R_W-1:0]  root_s [SQRT_STAGES+1];
	sqside_t         side_s [SQRT_STAGES+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = s;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam int B = SQRT_STAGES - 1 - k;
		logic [SQ_W+1:0] trial;
		logic            take;

		assign trial = ((SQ_W+2)'(root_s[k]) << (B + 1)) | ((SQ_W+2)'(1) << (2 * B));
		assign take  = trial <= (SQ_W+2)'(rem_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= take ? rem_s[k] - trial[SQ_W-1:0] : rem_s[k];
			root_s[k+1] <= take ? root_s[k] | (R_W'(1) << B) : root_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld  = vld_s[SQRT_STAGES];
	assign root     = root_s[SQRT_STAGES];
	assign out_side = side_s[SQRT_STAGES];

endmodule

[rtl/core/spgs_div.sv]
// Pipelined restoring divider of a scaled offset by the shared denominator, one bit per stage.
module spgs_div
	import spgs_pkg::*;
(
	input  logic             clk,
	input  logic [MAG_W-1:0] mag,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);

	logic [DEN_W-1:0] rem_s [DIV_STAGES+1];
	logic [DEN_W-1:0] den_s [DIV_STAGES+1];
	logic [Q_W-1:0]   quo_s [DIV_STAGES+1];

	// The dividend is the offset shifted up by 62 bits; all quotient bits above 62 are zero.
	assign rem_s[0] = DEN_W'(mag >> 1);
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic             nbit;
		logic [DEN_W:0]   cand;
		logic             take;

		if (j == 0) begin : g_first
			assign nbit = mag[0];
		end else begin : g_rest
			assign nbit = 1'b0;
		end

		assign cand = {rem_s[j], nbit};
		assign take = cand >= {1'b0, den_s[j]};

		always_ff @(posedge clk) begin
			rem_s[j+1] <= take ? DEN_W'(cand - {1'b0, den_s[j]}) : cand[DEN_W-1:0];
			den_s[j+1] <= den_s[j];
			quo_s[j+1] <= take ? quo_s[j] | (Q_W'(1) << (Q_W - 1 - j)) : quo_s[j];
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule

[rtl/core/smoothed_point_gravity_source.sv]
// Top level of the softened point-mass gravity source pipeline.
//
//  Channel  Signals                          Beat taken when
//  input    start, busy, point               start high and busy low
//  output   done, result                     every cycle done is high
//  config   cfg_valid, cfg_ready, cfg_index,  cfg_valid and cfg_ready high
//           cfg_data
//
// One point is taken every clock cycle; busy is always low and cfg_ready always high.
// Each result is set by its point through the 33-stage square root and the
// 63-stage dividers in series.
// Reset clears centre, width and all stage valid bits and sets eps to EPS_RESET.
// The receiver cannot stall: the pipeline never holds, no beat is lost or repeated.
module smoothed_point_gravity_source
	import spgs_pkg::*;
#(
	parameter int DIMENSION = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  point_t      point,
	output logic        done,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [LANES-1:0][31:0] center_q;
	logic [30:0]            eps_q;
	logic [31:0]            width_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			eps_q    <= EPS_RESET;
			width_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CENTER_X: center_q[0] <= cfg_data;
				CFG_CENTER_Y: center_q[1] <= cfg_data;
				CFG_CENTER_Z: center_q[2] <= cfg_data;
				CFG_EPS:      eps_q       <= cfg_data[30:0];
				CFG_WIDTH:    width_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: offsets from the centre.
	logic [LANES-1:0][31:0]  pos_a;
	logic [LANES-1:0][31:0]  mom_a;
	logic [LANES-1:0][D_W-1:0] d_in;
	logic                    accept;

	assign pos_a  = {point.pos_z, point.pos_y, point.pos_x};
	assign mom_a  = {point.mom_z, point.mom_y, point.mom_x};
	assign accept = start && !busy;

	for (genvar i = 0; i < LANES; i++) begin : g_off
		if (i < DIMENSION) begin : g_on
			assign d_in[i] = {pos_a[i][31], pos_a[i]} - {center_q[i][31], center_q[i]};
		end else begin : g_unused
			assign d_in[i] = '0;
		end
	end

	logic                      vld_s1;
	logic [LANES-1:0][D_W-1:0] d_s1;
	logic signed [31:0]        rho_s1;
	logic [LANES-1:0][31:0]    mom_s1;
	logic [30:0]               eps_s1;
	logic [32:0]               thr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		d_s1   <= d_in;
		rho_s1 <= point.mass_density;
		mom_s1 <= mom_a;
		eps_s1 <= (eps_q == '0) ? 31'd1 : eps_q;
		thr_s1 <= ONE_Q16 - {width_q[31], width_q};
	end

	// Stage 2: magnitudes and squares.
	logic                        vld_s2;
	logic [LANES-1:0][MAG_W-1:0] mag_s2;
	logic [LANES-1:0]            neg_s2;
	logic [LANES-1:0][SQ_W-1:0]  sq_s2;
	logic [ESQ_W-1:0]            esq_s2;
	logic                        thrneg_s2;
	logic [SQ_W-1:0]             thrsq_s2;
	logic signed [31:0]          rho_s2;
	logic [LANES-1:0][31:0]      mom_s2;

	for (genvar i = 0; i < LANES; i++) begin : g_sq
		logic [MAG_W-1:0] mag_c;
		assign mag_c = d_s1[i][D_W-1] ? MAG_W'(-d_s1[i]) : MAG_W'(d_s1[i]);
		always_ff @(posedge clk) begin
			mag_s2[i] <= mag_c;
			neg_s2[i] <= d_s1[i][D_W-1];
			sq_s2[i]  <= SQ_W'(mag_c) * SQ_W'(mag_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		esq_s2    <= ESQ_W'(eps_s1) * ESQ_W'(eps_s1);
		thrneg_s2 <= thr_s1[32];
		thrsq_s2  <= SQ_W'(thr_s1[31:0]) * SQ_W'(thr_s1[31:0]);
		rho_s2    <= rho_s1;
		mom_s2    <= mom_s1;
	end

	// Stage 3: squared length.
	logic                        vld_s3;
	logic [SQ_W-1:0]             s_s3;
	logic [LANES-1:0][MAG_W-1:0] mag_s3;
	logic [LANES-1:0]            neg_s3;
	logic [ESQ_W-1:0]            esq_s3;
	logic                        thrneg_s3;
	logic [SQ_W-1:0]             thrsq_s3;
	logic signed [31:0]          rho_s3;
	logic [LANES-1:0][31:0]      mom_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		s_s3      <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		mag_s3    <= mag_s2;
		neg_s3    <= neg_s2;
		esq_s3    <= esq_s2;
		thrneg_s3 <= thrneg_s2;
		thrsq_s3  <= thrsq_s2;
		rho_s3    <= rho_s2;
		mom_s3    <= mom_s2;
	end

	// Stage 4: choice of law and the factor that multiplies the root.
	logic            far_c;
	logic            zero_c;
	logic [SQ_W-1:0] x_c;

	assign zero_c = (s_s3 == '0);
	assign far_c  = thrneg_s3 || ({s_s3, 2'b00} > {2'b00, thrsq_s3});
	assign x_c    = zero_c ? SQ_W'(esq_s3) : (far_c ? s_s3 : s_s3 + SQ_W'(esq_s3));

	logic            vld_s4;
	logic [SQ_W-1:0] s_s4;
	sqside_t         side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		s_s4         <= s_s3;
		side_s4.x    <= x_c;
		side_s4.zero <= zero_c;
		side_s4.mag  <= mag_s3;
		side_s4.neg  <= neg_s3;
		side_s4.rho  <= rho_s3;
		side_s4.mom  <= mom_s3;
	end

	logic            sq_vld;
	logic [R_W-1:0]  sq_root;
	sqside_t         sq_side;

	spgs_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.s        (s_s4),
		.in_side  (side_s4),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.out_side (sq_side)
	);

	// Stage 5: partial products of the denominator.
	logic                  vld_s5;
	logic [2:0][PP_W-1:0]  pp_s5;
	sqside_t               side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= sq_vld;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_pp
		always_ff @(posedge clk) begin
			pp_s5[c] <= PP_W'(sq_side.x[c*X_CHUNK +: X_CHUNK]) * PP_W'(sq_root);
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= sq_side;
	end

	// Stage 6: denominator and divider operands.
	logic                        vld_s6;
	logic [DEN_W-1:0]            den_s6;
	logic [LANES-1:0][MAG_W-1:0] dmag_s6;
	dlside_t                     dl_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		den_s6 <= side_s5.zero ? DEN_W'(side_s5.x)
			: DEN_W'(pp_s5[0]) + (DEN_W'(pp_s5[1]) << X_CHUNK)
			+ (DEN_W'(pp_s5[2]) << (2 * X_CHUNK));
		for (int i = 0; i < LANES; i++) begin
			dmag_s6[i]   <= side_s5.zero ? MAG_W'(1) : side_s5.mag[i];
			dl_s6.neg[i] <= side_s5.zero ? 1'b0 : side_s5.neg[i];
		end
		dl_s6.rho <= side_s5.rho;
		dl_s6.mom <= side_s5.mom;
	end

	// Divider lanes with a matching delay line for the rest of the beat.
	logic [LANES-1:0][Q_W-1:0] quo;

	for (genvar i = 0; i < LANES; i++) begin : g_div
		if (i < DIMENSION) begin : g_on
			spgs_div u_div (
				.clk (clk),
				.mag (dmag_s6[i]),
				.den (den_s6),
				.quo (quo[i])
			);
		end else begin : g_unused
			assign quo[i] = '0;
		end
	end

	logic    dv_s  [DIV_STAGES];
	dlside_t dls_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else begin
				dv_s[k] <= (k == 0) ? vld_s6 : dv_s[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			dls_s[k] <= (k == 0) ? dl_s6 : dls_s[(k == 0) ? 0 : k-1];
		end
	end

	dlside_t dl_out;
	assign dl_out = dls_s[DIV_STAGES-1];

	// Stage 7: accelerations and partial products with density and momentum.
	logic                    vld_s7;
	logic [LANES-1:0][63:0]  rmh_s7;
	logic [LANES-1:0][64:0]  rml_s7;
	logic [LANES-1:0][63:0]  emh_s7;
	logic [LANES-1:0][64:0]  eml_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= dv_s[DIV_STAGES-1];
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_acc
		logic signed [ACC_W-1:0] acc;
		logic signed [31:0]      ahi;
		logic signed [32:0]      alo;
		logic signed [31:0]      rho;
		logic signed [31:0]      mv;

		assign acc = dl_out.neg[i] ? $signed(ACC_W'(quo[i])) : -$signed(ACC_W'(quo[i]));
		assign ahi = acc[63:32];
		assign alo = $signed({1'b0, acc[31:0]});
		assign rho = dl_out.rho;
		assign mv  = $signed(dl_out.mom[i]);

		always_ff @(posedge clk) begin
			rmh_s7[i] <= 64'(rho) * 64'(ahi);
			rml_s7[i] <= 65'(rho) * 65'(alo);
			emh_s7[i] <= 64'(mv) * 64'(ahi);
			eml_s7[i] <= 65'(mv) * 65'(alo);
		end
	end

	// Stage 8: full products.
	logic                       vld_s8;
	logic [LANES-1:0][PROD_W-1:0] pm_s8;
	logic [LANES-1:0][PROD_W-1:0] pe_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			pm_s8[i] <= {rmh_s7[i], 32'b0} + {{31{rml_s7[i][64]}}, rml_s7[i]};
			pe_s8[i] <= {emh_s7[i], 32'b0} + {{31{eml_s7[i][64]}}, eml_s7[i]};
		end
	end

	// Stage 9: energy sum and momentum source rounding.
	logic                   vld_s9;
	logic [SUM_W-1:0]       en_s9;
	logic [LANES-1:0][31:0] momv_s9;
	logic                   msat_s9;
	rnd_t                   rnd_m [LANES];

	for (genvar i = 0; i < LANES; i++) begin : g_rnd
		assign rnd_m[i] = round_sat({{2{pm_s8[i][PROD_W-1]}}, pm_s8[i]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		en_s9 <= {{2{pe_s8[0][PROD_W-1]}}, pe_s8[0]} + {{2{pe_s8[1][PROD_W-1]}}, pe_s8[1]}
			+ {{2{pe_s8[2][PROD_W-1]}}, pe_s8[2]};
		for (int i = 0; i < LANES; i++) begin
			momv_s9[i] <= rnd_m[i].value;
		end
		msat_s9 <= rnd_m[0].sat | rnd_m[1].sat | rnd_m[2].sat;
	end

	// Stage 10: energy rounding and the result register.
	rnd_t    rnd_e;
	logic    done_s10;
	result_t res_s10;

	assign rnd_e = round_sat(en_s9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s10 <= 1'b0;
		end else begin
			done_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		res_s10.src_mom_x  <= momv_s9[0];
		res_s10.src_mom_y  <= momv_s9[1];
		res_s10.src_mom_z  <= momv_s9[2];
		res_s10.src_energy <= rnd_e.value;
		res_s10.saturated  <= msat_s9 | rnd_e.sat;
	end

	assign done   = done_s10;
	assign result = res_s10;

endmodule

[rtl/core/spgs_chk.sv]
// Port-level checker for the gravity source, with its bind to the top level.
module spgs_chk
	import spgs_pkg::*;
#(
	parameter int DIMENSION = 3
) (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input point_t  point,
	input logic    done,
	input result_t result
);

	// Every accepted beat produces exactly one result after the fixed latency.
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("accepted beat produced no result");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without an accepted beat");

	// Zero density gives zero momentum source.
	a_zero_rho: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && point.mass_density == 32'sd0) |-> ##PIPE_LAT
		(result.src_mom_x == 32'sd0 && result.src_mom_y == 32'sd0
		&& result.src_mom_z == 32'sd0))
		else $error("nonzero momentum source for zero density");

	// Zero momentum gives zero energy source.
	a_zero_mom: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && point.mom_x == 32'sd0 && point.mom_y == 32'sd0
		&& point.mom_z == 32'sd0) |-> ##PIPE_LAT (result.src_energy == 32'sd0))
		else $error("nonzero energy source for zero momentum");

	// In two dimensions the z source stays zero.
	a_dim2: assert property (@(posedge clk) disable iff (!arst_n)
		(DIMENSION == 2 && done) |-> (result.src_mom_z == 32'sd0))
		else $error("z source nonzero in two dimensions");

endmodule

bind smoothed_point_gravity_source spgs_chk #(.DIMENSION(DIMENSION)) u_spgs_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.point  (point),
	.done   (done),
	.result (result)
);
